// ===== hw/rtl/ssc_pkg.sv =====
// ssc_pkg: shared widths, register indexes, structs and state types of the stereo cost block
`default_nettype none

package ssc_pkg;

    // fixed field widths
    localparam int ROW_W     = 10;
    localparam int COL_W     = 10;
    localparam int DISP_W    = 6;
    localparam int PIX_W     = 8;
    localparam int COST_W    = 8;
    localparam int NORM_W    = 16;
    localparam int SQ_W      = 22;
    localparam int CFG_W     = 11;
    localparam int BANK_W    = 5;
    localparam int REG_IDX_W = 1;
    localparam int XCOL_W    = 12;

    // offset that keeps window column arithmetic non-negative
    localparam int COL_BIAS  = 128;

    // job queue depth, power of two
    localparam int Q_DEPTH   = 2;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] MAX_HEIGHT   = 11'd1024;

    // one window center waiting for cost evaluation
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  top_row;
        logic [BANK_W-1:0] top_bank;
    } t_job;

    // line buffer write request
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [BANK_W-1:0] bank;
        logic [COL_W-1:0]  addr;
        logic [PIX_W-1:0]  left;
        logic [PIX_W-1:0]  right;
    } t_lb_wr;

    // back end status seen by the front end
    typedef struct packed {
        logic reading;
    } t_back_stat;

    // job queue status
    typedef struct packed {
        logic push;
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic {
        FS_CLEAR,
        FS_RUN
    } t_front_state;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_COST,
        BS_DRAIN,
        BS_NLOAD,
        BS_NINIT,
        BS_NSTEP,
        BS_NOUT
    } t_back_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ssc_pix_if.sv =====
// ssc_pix_if: pixel pair channel
`default_nettype none

interface ssc_pix_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] left_pixel;
    logic [7:0] right_pixel;

    modport source (output valid, output frame_start, output left_pixel,
                    output right_pixel, input ready);
    modport sink   (input valid, input frame_start, input left_pixel,
                    input right_pixel, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ssc_res_if.sv =====
// ssc_res_if: cost result channel
`default_nettype none

interface ssc_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  center_row;
    logic [9:0]  center_col;
    logic [5:0]  disparity;
    logic [7:0]  raw_cost;
    logic [15:0] norm_cost;
    logic        zero_vector;
    logic        last;

    modport source (output valid, output center_row, output center_col, output disparity,
                    output raw_cost, output norm_cost, output zero_vector, output last,
                    input ready);
    modport sink   (input valid, input center_row, input center_col, input disparity,
                    input raw_cost, input norm_cost, input zero_vector, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stereo_sad_cost_volume_top.sv =====
// stereo_sad_cost_volume_top: block-matching SAD cost volume with per-center L2 normalization
//
// Pixel pairs enter on i_pix in raster order; frame_start restarts the counters.
// Each interior window center yields DISPARITIES items on o_res, disparity 0 first,
// the final one flagged by last. image_width and image_height are to be written on the
// i_cfg port (index 0 and 1) only while the block is idle; the block does not enforce it.
// A center costs DISPARITIES*(2*HALF_WINDOW+1) line buffer reads, one window column of all
// rows per cycle, plus DISPARITIES passes of the 16-step normalization unit. The front
// keeps taking pixels of the same row while the back works, unless the job queue is full; at a
// row change or frame_start it waits until the job queue is empty and the back has finished
// reading the line buffers.
// After reset a clearing sweep over all MAX_WIDTH addresses zeroes the line buffers and no
// pixel is taken during it; configuration writes are taken at any time.
// A stalled o_res holds its item; the back waits in its output step meanwhile.
`default_nettype none

module stereo_sad_cost_volume_top
    import ssc_pkg::*;
#(
    parameter int DISPARITIES = 32,
    parameter int HALF_WINDOW = 2,
    parameter int MAX_WIDTH   = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ssc_pix_if.sink                   i_pix,
    ssc_res_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int WS = 2 * HALF_WINDOW + 1;
    localparam int AW = $clog2(MAX_WIDTH);

    t_job       w_push_job, w_head_job;
    t_lb_wr     w_lb_wr;
    t_back_stat w_back_stat;
    t_q_stat    w_q_stat;
    logic       w_pop, w_clearing;
    logic [AW-1:0] w_rd_addr_l, w_rd_addr_r;
    logic [WS*PIX_W-1:0] w_left, w_right;

    // intake and classification
    ssc_front #(
        .DISPARITIES (DISPARITIES),
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_back_stat (w_back_stat),
        .i_q_empty   (w_q_stat.empty),
        .i_q_full    (w_q_stat.full),
        .o_q_push    (w_q_stat.push),
        .o_job       (w_push_job),
        .o_lb_wr     (w_lb_wr),
        .o_clearing  (w_clearing)
    );

    // line buffers
    ssc_linebuf #(
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_linebuf (
        .i_clk       (i_clk),
        .i_wr        (w_lb_wr),
        .i_rd_addr_l (w_rd_addr_l),
        .i_rd_addr_r (w_rd_addr_r),
        .o_left      (w_left),
        .o_right     (w_right)
    );

    // job queue
    ssc_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_stat.push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_empty (w_q_stat.empty),
        .o_full  (w_q_stat.full)
    );

    // cost and normalization
    ssc_back #(
        .DISPARITIES (DISPARITIES),
        .HALF_WINDOW (HALF_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_stat.empty),
        .i_job       (w_head_job),
        .o_q_pop     (w_pop),
        .o_stat      (w_back_stat),
        .o_rd_addr_l (w_rd_addr_l),
        .o_rd_addr_r (w_rd_addr_r),
        .i_left      (w_left),
        .i_right     (w_right),
        .o_res       (o_res)
    );

    // no item taken during the clearing sweep
    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !i_pix.ready)
        else $error("item taken during line buffer clear");

    // queue never pushed when full
    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.push |-> !w_q_stat.full)
        else $error("job queue overflow");

    // last item of a center carries the top disparity
    a_last_on_top_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.disparity == DISP_W'(DISPARITIES - 1)))
        else $error("last flag on wrong disparity");

    // all-zero vector gives zero normalized cost
    a_zero_vector_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.zero_vector) |-> (o_res.norm_cost == '0))
        else $error("nonzero norm cost on zero vector");

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_linebuf.sv =====
// ssc_linebuf: banked left and right line buffers, one bank per window row
`default_nettype none

module ssc_linebuf
    import ssc_pkg::*;
#(
    parameter int HALF_WINDOW = 2,
    parameter int MAX_WIDTH   = 1024,
    localparam int WS = 2 * HALF_WINDOW + 1,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                i_clk,
    input  wire t_lb_wr              i_wr,
    input  wire logic [AW-1:0]       i_rd_addr_l,
    input  wire logic [AW-1:0]       i_rd_addr_r,
    output logic [WS*PIX_W-1:0]      o_left,
    output logic [WS*PIX_W-1:0]      o_right
);

    logic [AW-1:0] w_wr_addr;

    assign w_wr_addr = i_wr.addr[AW-1:0];

    for (genvar b = 0; b < WS; b++) begin : g_bank
        logic [PIX_W-1:0] r_left_mem  [MAX_WIDTH];
        logic [PIX_W-1:0] r_right_mem [MAX_WIDTH];
        logic [PIX_W-1:0] r_left_rd;
        logic [PIX_W-1:0] r_right_rd;

        // write: clearing sweep hits every bank, a pixel only its own row bank
        always_ff @(posedge i_clk) begin
            if (i_wr.clear) begin
                r_left_mem[w_wr_addr]  <= '0;
                r_right_mem[w_wr_addr] <= '0;
            end else if (i_wr.en && (i_wr.bank == BANK_W'(b))) begin
                r_left_mem[w_wr_addr]  <= i_wr.left;
                r_right_mem[w_wr_addr] <= i_wr.right;
            end
        end

        // registered reads
        always_ff @(posedge i_clk) begin
            r_left_rd  <= r_left_mem[i_rd_addr_l];
            r_right_rd <= r_right_mem[i_rd_addr_r];
        end

        assign o_left[b*PIX_W +: PIX_W]  = r_left_rd;
        assign o_right[b*PIX_W +: PIX_W] = r_right_rd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_front.sv =====
// ssc_front: pixel intake, raster counters, line buffer writes and center classification
`default_nettype none

module ssc_front
    import ssc_pkg::*;
#(
    parameter int DISPARITIES = 32,
    parameter int HALF_WINDOW = 2,
    parameter int MAX_WIDTH   = 1024,
    localparam int WS = 2 * HALF_WINDOW + 1,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ssc_pix_if.sink                   i_pix,
    input  wire logic                 i_cfg_we,
    input  wire logic [REG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire t_back_stat           i_back_stat,
    input  wire logic                 i_q_empty,
    input  wire logic                 i_q_full,
    output logic                      o_q_push,
    output t_job                      o_job,
    output t_lb_wr                    o_lb_wr,
    output logic                      o_clearing
);

    t_front_state r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [BANK_W-1:0] r_bank;
    logic [CFG_W-1:0]  r_width, r_height;

    logic [CFG_W-1:0]  w_w, w_h;
    logic [ROW_W-1:0]  w_row;
    logic [COL_W-1:0]  w_col;
    logic [BANK_W-1:0] w_bank;
    logic              w_safe, w_accept, w_interior;
    logic [XCOL_W-1:0] w_row_x, w_col_x;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        w_w = r_width;
        if (r_width == '0) w_w = CFG_W'(1);
        else if (r_width > CFG_W'(MAX_WIDTH)) w_w = CFG_W'(MAX_WIDTH);
        w_h = r_height;
        if (r_height == '0) w_h = CFG_W'(1);
        else if (r_height > MAX_HEIGHT) w_h = MAX_HEIGHT;
    end

    // position of the incoming item
    assign w_row  = i_pix.frame_start ? '0 : r_row;
    assign w_col  = i_pix.frame_start ? '0 : r_col;
    assign w_bank = i_pix.frame_start ? '0 : r_bank;

    // a pending job only reads columns left of the current one in this row
    assign w_safe = (i_q_empty && !i_back_stat.reading) ||
                    ((r_col != '0) && !i_pix.frame_start);

    assign i_pix.ready = (r_state == FS_RUN) && !i_q_full && w_safe;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // interior test on the completed center
    assign w_row_x = XCOL_W'(w_row);
    assign w_col_x = XCOL_W'(w_col);
    assign w_interior =
        (w_row_x >= XCOL_W'(DISPARITIES + HALF_WINDOW)) &&
        (w_col_x >= XCOL_W'(DISPARITIES + HALF_WINDOW)) &&
        ((w_row_x + XCOL_W'(DISPARITIES)) < (XCOL_W'(w_h) + XCOL_W'(HALF_WINDOW))) &&
        ((w_col_x + XCOL_W'(DISPARITIES)) < (XCOL_W'(w_w) + XCOL_W'(HALF_WINDOW)));

    // job toward the queue
    assign o_q_push       = w_accept && w_interior;
    assign o_job.row      = w_row - ROW_W'(HALF_WINDOW);
    assign o_job.col      = w_col - COL_W'(HALF_WINDOW);
    assign o_job.top_row  = w_row;
    assign o_job.top_bank = w_bank;

    // line buffer write or clearing sweep
    always_comb begin
        o_lb_wr.clear = (r_state == FS_CLEAR);
        o_lb_wr.en    = w_accept && (CFG_W'(w_col) < CFG_W'(MAX_WIDTH));
        o_lb_wr.bank  = w_bank;
        o_lb_wr.addr  = (r_state == FS_CLEAR) ? COL_W'(r_clr_addr) : w_col;
        o_lb_wr.left  = i_pix.left_pixel;
        o_lb_wr.right = i_pix.right_pixel;
    end

    assign o_clearing = (r_state == FS_CLEAR);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_CLEAR: if (r_clr_addr == AW'(MAX_WIDTH - 1)) n_state = FS_RUN;
            FS_RUN:   n_state = FS_RUN;
            default:  n_state = FS_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= FS_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == FS_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= '0;
        end else if (w_accept) begin
            if ((CFG_W'(w_col) + CFG_W'(1)) >= w_w) begin
                r_col <= '0;
                if ((CFG_W'(w_row) + CFG_W'(1)) >= w_h) begin
                    r_row  <= '0;
                    r_bank <= '0;
                end else begin
                    r_row  <= w_row + ROW_W'(1);
                    r_bank <= (w_bank == BANK_W'(WS - 1)) ? '0 : w_bank + BANK_W'(1);
                end
            end else begin
                r_row  <= w_row;
                r_bank <= w_bank;
                r_col  <= w_col + COL_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_jobq.sv =====
// ssc_jobq: short job queue between front and back
`default_nettype none

module ssc_jobq
    import ssc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PW = $clog2(Q_DEPTH);

    t_job          r_slots [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;

    assign o_job   = r_slots[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PW+1)'(Q_DEPTH));

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_push) r_slots[r_wr_ptr] <= i_job;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            if (i_push && !i_pop)      r_count <= r_count + (PW+1)'(1);
            else if (i_pop && !i_push) r_count <= r_count - (PW+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_back.sv =====
// ssc_back: window costs, square sum, bit-serial normalization and result output
`default_nettype none

module ssc_back
    import ssc_pkg::*;
#(
    parameter int DISPARITIES = 32,
    parameter int HALF_WINDOW = 2,
    parameter int MAX_WIDTH   = 1024,
    localparam int WS = 2 * HALF_WINDOW + 1,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_empty,
    input  wire t_job                i_job,
    output logic                     o_q_pop,
    output t_back_stat               o_stat,
    output logic [AW-1:0]            o_rd_addr_l,
    output logic [AW-1:0]            o_rd_addr_r,
    input  wire logic [WS*PIX_W-1:0] i_left,
    input  wire logic [WS*PIX_W-1:0] i_right,
    ssc_res_if.source                o_res
);

    localparam int WA       = WS * WS;
    localparam int JW       = (WS > 1) ? $clog2(WS) : 1;
    localparam int DW       = (DISPARITIES > 1) ? $clog2(DISPARITIES) : 1;
    localparam int CS_W     = $clog2(WS * 255 + 1);
    localparam int SUM_W    = $clog2(WA * 255 + 1);
    localparam int RECIP_SH = SUM_W + $clog2(WA);
    localparam int RECIP    = (2 ** RECIP_SH + WA - 1) / WA;
    localparam int PROD_W   = SUM_W + RECIP_SH + 1;
    localparam int NW       = SQ_W + 2 * NORM_W + 2;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [WS-1:0] r_row_ok, w_row_ok;
    logic [DW-1:0] r_d;
    logic [JW-1:0] r_j;

    // cost pipeline
    logic              r_s1_valid, r_s1_lok, r_s1_rok, r_s1_first, r_s1_last;
    logic [DW-1:0]     r_s1_d;
    logic              r_s2_valid, r_s2_first, r_s2_last;
    logic [DW-1:0]     r_s2_d;
    logic [CS_W-1:0]   r_s2_sum;
    logic [SUM_W-1:0]  r_acc;
    logic              r_s3_valid;
    logic [DW-1:0]     r_s3_d;
    logic [SUM_W-1:0]  r_s3_total;
    logic              r_s4_valid;
    logic [DW-1:0]     r_s4_d;
    logic [PROD_W-1:0] r_prod;
    logic [SQ_W-1:0]   r_sq;
    logic [COST_W-1:0] r_cost_mem [DISPARITIES];
    logic [COST_W-1:0] r_cost_rd;

    // normalization
    logic [COST_W-1:0] r_cost;
    logic [2*COST_W-1:0] r_tgt;
    logic [NW-1:0]     r_p, r_tb, r_sb;
    logic [NORM_W-1:0] r_q;
    logic [3:0]        r_b;
    logic              r_zero;

    // output register
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [DISP_W-1:0] r_out_disp;
    logic [COST_W-1:0] r_out_raw;
    logic [NORM_W-1:0] r_out_norm;
    logic              r_out_zero, r_out_last;

    logic              w_issue, w_issue_last, w_out_load, w_pipe_busy;
    logic [XCOL_W-1:0] w_lx, w_rx, w_lidx, w_ridx;
    logic              w_lok, w_rok;
    logic [CS_W-1:0]   w_colsum;
    logic [SUM_W-1:0]  w_acc_sum;
    logic [COST_W-1:0] w_cost;
    logic [2*COST_W-1:0] w_cost_sq;
    logic [NW-1:0]     w_cand, w_target;
    logic              w_take;

    // row banks holding valid rows for a new job
    always_comb begin
        logic [BANK_W-1:0] k;
        for (int b = 0; b < WS; b++) begin
            k = (i_job.top_bank >= BANK_W'(b)) ? i_job.top_bank - BANK_W'(b)
                                               : i_job.top_bank + BANK_W'(WS - b);
            w_row_ok[b] = (ROW_W'(k) <= i_job.top_row);
        end
    end

    // window column addresses for the current disparity and column offset
    always_comb begin
        w_lx   = XCOL_W'(r_job.col) + XCOL_W'(r_j) + XCOL_W'(COL_BIAS - HALF_WINDOW);
        w_rx   = w_lx - XCOL_W'(r_d);
        w_lidx = w_lx - XCOL_W'(COL_BIAS);
        w_ridx = w_rx - XCOL_W'(COL_BIAS);
        w_lok  = (w_lx >= XCOL_W'(COL_BIAS)) && (w_lidx < XCOL_W'(MAX_WIDTH));
        w_rok  = (w_rx >= XCOL_W'(COL_BIAS)) && (w_ridx < XCOL_W'(MAX_WIDTH));
    end

    assign o_rd_addr_l = w_lidx[AW-1:0];
    assign o_rd_addr_r = w_ridx[AW-1:0];

    // column sum of absolute differences over the window rows
    always_comb begin
        logic [PIX_W-1:0] lp, rp, ad;
        w_colsum = '0;
        for (int b = 0; b < WS; b++) begin
            lp = r_s1_lok ? i_left[b*PIX_W +: PIX_W] : '0;
            rp = r_s1_rok ? i_right[b*PIX_W +: PIX_W] : '0;
            ad = (lp > rp) ? lp - rp : rp - lp;
            if (r_row_ok[b]) w_colsum = w_colsum + CS_W'(ad);
        end
    end

    assign w_acc_sum = (r_s2_first ? '0 : r_acc) + SUM_W'(r_s2_sum);
    assign w_cost    = COST_W'(r_prod >> RECIP_SH);
    assign w_cost_sq = w_cost * w_cost;

    // trial bit of the quotient: q*q*s kept incrementally as shifted sums
    assign w_target = NW'({r_tgt, 32'b0});
    assign w_cand   = r_p + r_tb + r_sb;
    assign w_take   = (w_cand <= w_target);

    assign w_issue_last = (r_d == DW'(DISPARITIES - 1)) && (r_j == JW'(2 * HALF_WINDOW));
    assign w_pipe_busy  = r_s1_valid || r_s2_valid || r_s3_valid || r_s4_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE:  if (!i_q_empty) n_state = BS_COST;
            BS_COST:  if (w_issue_last) n_state = BS_DRAIN;
            BS_DRAIN: if (!w_pipe_busy) n_state = BS_NLOAD;
            BS_NLOAD: n_state = BS_NINIT;
            BS_NINIT: n_state = BS_NSTEP;
            BS_NSTEP: if (r_b == 4'd0) n_state = BS_NOUT;
            BS_NOUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = (r_d == DW'(DISPARITIES - 1)) ? BS_IDLE : BS_NLOAD;
                end
            end
            default:  n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_q_pop        = (r_state == BS_IDLE) && !i_q_empty;
        w_issue        = (r_state == BS_COST);
        w_out_load     = (r_state == BS_NOUT) && (!r_out_valid || o_res.ready);
        o_stat.reading = (r_state == BS_COST) || (r_state == BS_DRAIN);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_d         <= '0;
            r_j         <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_last;
            r_s4_valid <= r_s3_valid;
            if (o_q_pop) begin
                r_d <= '0;
                r_j <= '0;
            end else if (w_issue) begin
                if (r_j == JW'(2 * HALF_WINDOW)) begin
                    r_j <= '0;
                    r_d <= w_issue_last ? '0 : r_d + DW'(1);
                end else begin
                    r_j <= r_j + JW'(1);
                end
            end else if (w_out_load && (r_d != DW'(DISPARITIES - 1))) begin
                r_d <= r_d + DW'(1);
            end
            if (w_out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    // cost pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job    <= i_job;
            r_row_ok <= w_row_ok;
            r_sq     <= '0;
        end
        r_s1_lok   <= w_lok;
        r_s1_rok   <= w_rok;
        r_s1_first <= (r_j == '0);
        r_s1_last  <= (r_j == JW'(2 * HALF_WINDOW));
        r_s1_d     <= r_d;
        r_s2_sum   <= w_colsum;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_d     <= r_s1_d;
        if (r_s2_valid) r_acc <= w_acc_sum;
        r_s3_total <= w_acc_sum;
        r_s3_d     <= r_s2_d;
        r_prod     <= PROD_W'(r_s3_total) * PROD_W'(RECIP);
        r_s4_d     <= r_s3_d;
        if (r_s4_valid) begin
            r_cost_mem[r_s4_d] <= w_cost;
            r_sq               <= r_sq + SQ_W'(w_cost_sq);
        end
        r_cost_rd <= r_cost_mem[r_d];
    end

    // normalization datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_NINIT: begin
                r_cost <= r_cost_rd;
                r_tgt  <= r_cost_rd * r_cost_rd;
                r_sb   <= NW'({r_sq, 30'b0});
                r_tb   <= '0;
                r_p    <= '0;
                r_q    <= '0;
                r_b    <= 4'd15;
                r_zero <= (r_sq == '0);
            end
            BS_NSTEP: begin
                if (w_take) begin
                    r_p  <= w_cand;
                    r_tb <= (r_tb + (r_sb << 1)) >> 1;
                    r_q  <= r_q | (NORM_W'(1) << r_b);
                end else begin
                    r_tb <= r_tb >> 1;
                end
                r_sb <= r_sb >> 2;
                r_b  <= r_b - 4'd1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_row  <= r_job.row;
            r_out_col  <= r_job.col;
            r_out_disp <= DISP_W'(r_d);
            r_out_raw  <= r_cost;
            r_out_norm <= r_zero ? '0 : r_q;
            r_out_zero <= r_zero;
            r_out_last <= (r_d == DW'(DISPARITIES - 1));
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.center_row  = r_out_row;
    assign o_res.center_col  = r_out_col;
    assign o_res.disparity   = r_out_disp;
    assign o_res.raw_cost    = r_out_raw;
    assign o_res.norm_cost   = r_out_norm;
    assign o_res.zero_vector = r_out_zero;
    assign o_res.last        = r_out_last;

endmodule

`default_nettype wire
